### src/rffs_pkg.sv
package rffs_pkg;

	// slot store geometry, the tree is a full heap with leaves at SLOTS + slot
	localparam int SLOTS  = 1024;
	localparam int LVLS   = $clog2(SLOTS);
	localparam int IDX_W  = LVLS;
	localparam int NODE_W = LVLS + 1;
	localparam int CNT_W  = LVLS + 1;
	localparam int NODES  = 2 * SLOTS;

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_FIND     = 2'd1,
		CMD_FIND_CLR = 2'd2
	} cmd_t;

	// one port count memory access
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] addr;
		logic [CNT_W-1:0]  wdata;
	} mem_req_t;

	// finished result word from the sequencer
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] available_total;
	} res_t;

endpackage

### src/range_first_set_slot_finder_top.sv
// Range first-set slot finder. Keeps SLOTS availability marks in a count tree
// held in one single-port memory (node n has children 2n and 2n+1, slot s is
// leaf SLOTS+s), and answers one command per input word: cmd 0 writes a mark,
// cmd 1 returns the lowest set slot in [range_low, range_high], cmd 2 does the
// same and clears that slot; every word gives exactly one result word with
// the root count after the command. After reset the block sweeps the whole
// count memory to zero, one node per cycle, with in_stall high. A no-op or
// an empty range goes straight to its result and a write that leaves the
// mark as it was stops at the leaf; the longest command is a find and clear
// that climbs to a child of the root, descends the full tree and then
// rewrites the path, since every tree step is one registered read of the
// count memory: a write sets the leaf, then reads each level above and
// writes back the count moved by one; a find climbs from the start leaf
// over empty right siblings, then descends to the lowest set leaf.
// in_stall is high while a word is at work; a finished result sits in the
// output register and the next word may be accepted while it waits.
module range_first_set_slot_finder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [rffs_pkg::IDX_W-1:0] slot_index,
	input  logic                       write_value,
	input  logic [rffs_pkg::IDX_W-1:0] range_low,
	input  logic [rffs_pkg::IDX_W-1:0] range_high,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [rffs_pkg::IDX_W-1:0] found_index,
	output logic [rffs_pkg::CNT_W-1:0] available_total
);
	import rffs_pkg::*;

	// sequencer to memory and to the output register
	mem_req_t         mem_req;
	logic [CNT_W-1:0] rd_data;
	res_t             res;
	logic             res_valid;
	logic             res_room;

	// output register is free when empty or being taken this cycle
	logic             out_valid_q;
	res_t             out_q;

	assign res_room = !out_valid_q || !out_stall;

	rffs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.slot_index  (slot_index),
		.write_value (write_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.res_room    (res_room),
		.res_valid   (res_valid),
		.res         (res),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	// count tree storage, registered read
	rffs_count_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_room) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_room && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = out_q.found;
	assign found_index     = out_q.found_index;
	assign available_total = out_q.available_total;

endmodule

### src/rffs_count_mem.sv
module rffs_count_mem (
	input  logic                clk,
	input  rffs_pkg::mem_req_t  req,
	output logic [rffs_pkg::CNT_W-1:0] rd_data
);
	import rffs_pkg::*;

	logic [CNT_W-1:0] mem_q [NODES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		rd_data <= mem_q[req.addr];
	end

endmodule

### src/rffs_seq.sv
module rffs_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [rffs_pkg::IDX_W-1:0] slot_index,
	input  logic                       write_value,
	input  logic [rffs_pkg::IDX_W-1:0] range_low,
	input  logic [rffs_pkg::IDX_W-1:0] range_high,
	input  logic                       res_room,
	output logic                       res_valid,
	output rffs_pkg::res_t             res,
	output rffs_pkg::mem_req_t         mem_req,
	input  logic [rffs_pkg::CNT_W-1:0] rd_data
);
	import rffs_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR   = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_UPD_RD  = 9'b000000100,
		ST_UPD_WR  = 9'b000001000,
		ST_F_RD    = 9'b000010000,
		ST_F_CHK   = 9'b000100000,
		ST_F_CLIMB = 9'b001000000,
		ST_F_DESC  = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		PH_LEAF = 2'd0,
		PH_SIB  = 2'd1,
		PH_DESC = 2'd2
	} phase_t;

	state_t            state_q, state_d;
	logic [NODE_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0]  root_q, root_d;

	logic [NODE_W-1:0] node_q, node_d;
	phase_t            phase_q, phase_d;
	logic              inc_q, inc_d;
	logic              mark_q, mark_d;
	logic [1:0]        cmd_q, cmd_d;
	logic [IDX_W-1:0]  qh_q, qh_d;
	logic              hit_q, hit_d;
	logic [IDX_W-1:0]  idx_q, idx_d;

	logic              nz;
	logic              leaf;
	logic [CNT_W-1:0]  adj;

	// shared unit: zero test and +/-1 on the word just read
	assign nz   = |rd_data;
	assign leaf = node_q[LVLS];
	assign adj  = inc_q ? rd_data + CNT_W'(1) : rd_data - CNT_W'(1);

	assign in_stall        = (state_q != ST_IDLE);
	assign res_valid       = (state_q == ST_DONE);
	assign res.found       = hit_q;
	assign res.found_index = idx_q;
	assign res.available_total = root_q;

	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		root_d  = root_q;
		node_d  = node_q;
		phase_d = phase_q;
		inc_d   = inc_q;
		mark_d  = mark_q;
		cmd_d   = cmd_q;
		qh_d    = qh_q;
		hit_d   = hit_q;
		idx_d   = idx_q;
		mem_req = '{we: 1'b0, addr: node_q, wdata: '0};

		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
				clr_d        = clr_q + NODE_W'(1);
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd_d  = cmd;
					mark_d = write_value;
					qh_d   = range_high;
					hit_d  = 1'b0;
					idx_d  = '0;
					unique case (cmd)
						CMD_WRITE: begin
							node_d  = {1'b1, slot_index};
							state_d = ST_UPD_RD;
						end
						CMD_FIND, CMD_FIND_CLR: begin
							if (range_low > range_high) begin
								state_d = ST_DONE;
							end else begin
								node_d  = {1'b1, range_low};
								phase_d = PH_LEAF;
								state_d = ST_F_RD;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_UPD_RD: begin
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				if (leaf) begin
					if (rd_data == CNT_W'(mark_q)) begin
						state_d = ST_DONE;
					end else begin
						mem_req.we    = 1'b1;
						mem_req.wdata = CNT_W'(mark_q);
						inc_d         = mark_q;
						node_d        = node_q >> 1;
						state_d       = ST_UPD_RD;
					end
				end else begin
					mem_req.we    = 1'b1;
					mem_req.wdata = adj;
					if (node_q == ROOT_NODE) begin
						root_d  = adj;
						state_d = ST_DONE;
					end else begin
						node_d  = node_q >> 1;
						state_d = ST_UPD_RD;
					end
				end
			end
			ST_F_RD: begin
				state_d = ST_F_CHK;
			end
			ST_F_CHK: begin
				unique case (phase_q)
					PH_LEAF, PH_SIB: begin
						state_d = nz ? ST_F_DESC : ST_F_CLIMB;
					end
					PH_DESC: begin
						// left child empty: the right one holds the set mark
						if (!nz) begin
							node_d = node_q + NODE_W'(1);
						end
						state_d = ST_F_DESC;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_F_CLIMB: begin
				if (node_q == ROOT_NODE) begin
					state_d = ST_DONE;
				end else if (node_q[0]) begin
					node_d = node_q >> 1;
				end else begin
					node_d  = node_q + NODE_W'(1);
					phase_d = PH_SIB;
					state_d = ST_F_RD;
				end
			end
			ST_F_DESC: begin
				if (leaf) begin
					if (node_q[IDX_W-1:0] <= qh_q) begin
						hit_d = 1'b1;
						idx_d = node_q[IDX_W-1:0];
						if (cmd_q == CMD_FIND_CLR) begin
							mark_d  = 1'b0;
							state_d = ST_UPD_RD;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					node_d  = {node_q[NODE_W-2:0], 1'b0};
					phase_d = PH_DESC;
					state_d = ST_F_RD;
				end
			end
			ST_DONE: begin
				if (res_room) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			root_q  <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			root_q  <= root_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q  <= node_d;
		phase_q <= phase_d;
		inc_q   <= inc_d;
		mark_q  <= mark_d;
		cmd_q   <= cmd_d;
		qh_q    <= qh_d;
		hit_q   <= hit_d;
		idx_q   <= idx_d;
	end

endmodule

### src/rffs_checker.sv
module rffs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [1:0]                 cmd,
	input logic [rffs_pkg::IDX_W-1:0] slot_index,
	input logic                       write_value,
	input logic [rffs_pkg::IDX_W-1:0] range_low,
	input logic [rffs_pkg::IDX_W-1:0] range_high,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       found,
	input logic [rffs_pkg::IDX_W-1:0] found_index,
	input logic [rffs_pkg::CNT_W-1:0] available_total
);
	import rffs_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found)
			&& $stable(found_index) && $stable(available_total))
		else $error("stalled result word changed");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again without working the word");

	a_not_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_index == '0)
		else $error("index not zero on a miss");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> available_total <= CNT_W'(SLOTS))
		else $error("root count above slot count");

endmodule

bind range_first_set_slot_finder_top rffs_checker u_chk (.*);
